// ===== hw/rtl/gbn_pkg.sv =====
package gbn_pkg;

    // Field widths
    localparam int IDX_W   = 16;
    localparam int TIME_W  = 32;
    localparam int TICKS_W = 16;
    localparam int CNT_W   = 8;
    localparam int KIND_W  = 2;
    localparam int SEQ_W   = 4;
    localparam int SEQ_EXT_W = 8;   // holds any sequence count for SEQ_MOD up to 256

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CANCEL_LIMIT  = 2'd2;

    localparam logic [IDX_W-1:0]   TOTAL_PACKETS_RST = 16'd1;
    localparam logic [TICKS_W-1:0] TIMEOUT_TICKS_RST = 16'd10;
    localparam logic [CNT_W-1:0]   CANCEL_LIMIT_RST  = 8'd10;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // Reply kinds
    localparam logic [KIND_W-1:0] RX_ACK = 2'd0;
    localparam logic [KIND_W-1:0] RX_NAK = 2'd1;

    // Default geometry
    localparam int WINDOW_DEF  = 8;
    localparam int SEQ_MOD_DEF = 16;

    typedef struct packed {
        logic              restart;
        logic [TIME_W-1:0] now_ms;
        logic              rx_valid;
        logic [KIND_W-1:0] rx_kind;
        logic [SEQ_W-1:0]  rx_seq;
    } in_item_t;

    typedef struct packed {
        logic             send_valid;
        logic [IDX_W-1:0] send_index;
        logic [SEQ_W-1:0] send_seq;
        logic             timeout_event;
        logic             failed;
        logic             done_res;
        logic [IDX_W-1:0] base_index;
    } out_item_t;

endpackage

// ===== hw/rtl/gbn_in_if.sv =====
interface gbn_in_if;
    import gbn_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gbn_out_if.sv =====
interface gbn_out_if;
    import gbn_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/go_back_n_sender_window_core.sv =====
// Go-Back-N sender window control. Each input beat is one step of the sender
// loop and yields exactly one result beat: a send of the next packet inside the
// window, a timeout rewind when the base packet's timer has run out, or neither,
// then handling of a received ACK/NAK. failed and done_res are sticky until a
// beat with restart set. Throughput is one beat per cycle while results are
// taken: the whole step is a few compares and counter updates on the window
// registers, done in the cycle the beat is taken; the result lands in an output
// register. A stalled result holds in_ch.ready low only while the output
// register is full and not being taken. Configuration is written by the user
// only while no step is pending, through cfg_we/cfg_index/cfg_data; the block
// does not enforce it. Writes to an index beyond the register list are dropped.
// Slot send times have no reset; a slot is always stamped before the timer reads it.
module go_back_n_sender_window_core #(
    parameter int WINDOW  = gbn_pkg::WINDOW_DEF,
    parameter int SEQ_MOD = gbn_pkg::SEQ_MOD_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
    gbn_in_if.sink                          in_ch,
    gbn_out_if.source                       out_ch
);
    import gbn_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SQ_W   = $clog2(SEQ_MOD);

    // Configuration registers
    logic [IDX_W-1:0]   total_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic [CNT_W-1:0]   limit_reg;

    // Window state; the mod-WINDOW and mod-SEQ_MOD counters track base and next
    logic [IDX_W-1:0]  base_reg,      base_next;
    logic [SLOT_W-1:0] base_slot_reg, base_slot_next;
    logic [SQ_W-1:0]   base_seq_reg,  base_seq_next;
    logic [IDX_W-1:0]  nxt_reg,       nxt_next;
    logic [SLOT_W-1:0] nxt_slot_reg,  nxt_slot_next;
    logic [SQ_W-1:0]   nxt_seq_reg,   nxt_seq_next;
    logic [CNT_W-1:0]  cnt_reg,       cnt_next;
    logic              done_reg,      done_next;
    logic              fail_reg,      fail_next;

    logic [TIME_W-1:0] slot_mem [WINDOW];

    // Output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg,  out_data_next;

    logic in_fire;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign in_fire      = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    // Step logic
    logic [IDX_W-1:0]  c_base, c_nxt;
    logic [SLOT_W-1:0] c_base_slot, c_nxt_slot;
    logic [SQ_W-1:0]   c_base_seq, c_nxt_seq;
    logic [CNT_W-1:0]  c_cnt;
    logic              c_done, c_fail;
    logic              active, do_send, expired, tmo, failing, rx_take;
    logic [TIME_W-1:0] elapsed;
    logic [SQ_W-1:0]   want_seq;
    logic [SLOT_W-1:0] inc_base_slot;
    logic [SQ_W-1:0]   inc_base_seq;
    logic [IDX_W-1:0]  inc_base;
    logic [SEQ_EXT_W-1:0] seq_ext, want_ext;

    always_comb
    begin
        // restart clears the transfer before the step runs
        c_base      = in_ch.data.restart ? '0 : base_reg;
        c_base_slot = in_ch.data.restart ? '0 : base_slot_reg;
        c_base_seq  = in_ch.data.restart ? '0 : base_seq_reg;
        c_nxt       = in_ch.data.restart ? '0 : nxt_reg;
        c_nxt_slot  = in_ch.data.restart ? '0 : nxt_slot_reg;
        c_nxt_seq   = in_ch.data.restart ? '0 : nxt_seq_reg;
        c_cnt       = in_ch.data.restart ? '0 : cnt_reg;
        c_done      = in_ch.data.restart ? 1'b0 : done_reg;
        c_fail      = in_ch.data.restart ? 1'b0 : fail_reg;

        // a shrunk total ends the transfer before anything else
        if (!c_done && !c_fail && (c_base >= total_reg))
            c_done = 1'b1;
        active = !c_done && !c_fail;

        do_send = active
                  && ({1'b0, c_nxt} < ({1'b0, c_base} + (IDX_W+1)'(WINDOW)))
                  && (c_nxt < total_reg);

        elapsed = in_ch.data.now_ms - slot_mem[c_base_slot];
        expired = elapsed >= TIME_W'(ticks_reg);
        tmo     = active && !do_send && expired;

        base_next      = c_base;
        base_slot_next = c_base_slot;
        base_seq_next  = c_base_seq;
        nxt_next       = c_nxt;
        nxt_slot_next  = c_nxt_slot;
        nxt_seq_next   = c_nxt_seq;
        cnt_next       = c_cnt;
        done_next      = c_done;
        fail_next      = c_fail;
        failing        = 1'b0;

        if (do_send)
        begin
            nxt_next      = c_nxt + 1'b1;
            nxt_slot_next = (c_nxt_slot == SLOT_W'(WINDOW - 1)) ? '0 : c_nxt_slot + 1'b1;
            nxt_seq_next  = (c_nxt_seq == SQ_W'(SEQ_MOD - 1)) ? '0 : c_nxt_seq + 1'b1;
        end
        else if (tmo)
        begin
            nxt_next      = c_base;
            nxt_slot_next = c_base_slot;
            nxt_seq_next  = c_base_seq;
            if (c_cnt != CNT_MAX)
                cnt_next = c_cnt + 1'b1;
            if (cnt_next > limit_reg)
            begin
                fail_next = 1'b1;
                failing   = 1'b1;
            end
        end

        // reply handling
        inc_base      = c_base + 1'b1;
        inc_base_slot = (c_base_slot == SLOT_W'(WINDOW - 1)) ? '0 : c_base_slot + 1'b1;
        inc_base_seq  = (c_base_seq == SQ_W'(SEQ_MOD - 1)) ? '0 : c_base_seq + 1'b1;
        want_seq      = inc_base_seq;
        want_ext      = SEQ_EXT_W'(want_seq);
        rx_take       = active && !failing && in_ch.data.rx_valid;

        if (rx_take)
        begin
            cnt_next = '0;
            if (in_ch.data.rx_kind == RX_ACK)
            begin
                if (in_ch.data.rx_seq == want_ext[SEQ_W-1:0])
                begin
                    base_next      = inc_base;
                    base_slot_next = inc_base_slot;
                    base_seq_next  = inc_base_seq;
                    if (nxt_next < inc_base)
                    begin
                        nxt_next      = inc_base;
                        nxt_slot_next = inc_base_slot;
                        nxt_seq_next  = inc_base_seq;
                    end
                end
            end
            else if (in_ch.data.rx_kind == RX_NAK)
            begin
                nxt_next      = c_base;
                nxt_slot_next = c_base_slot;
                nxt_seq_next  = c_base_seq;
            end
        end

        if (active && !failing && (base_next >= total_reg))
            done_next = 1'b1;

        seq_ext = SEQ_EXT_W'(c_nxt_seq);
        out_data_next.send_valid    = do_send;
        out_data_next.send_index    = do_send ? c_nxt : '0;
        out_data_next.send_seq      = do_send ? seq_ext[SEQ_W-1:0] : '0;
        out_data_next.timeout_event = tmo;
        out_data_next.failed        = fail_next;
        out_data_next.done_res      = done_next;
        out_data_next.base_index    = base_next;
    end

    always_comb
    begin
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_PACKETS_RST;
            ticks_reg <= TIMEOUT_TICKS_RST;
            limit_reg <= CANCEL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOTAL_PACKETS: total_reg <= cfg_data[IDX_W-1:0];
                CFG_TIMEOUT_TICKS: ticks_reg <= cfg_data[TICKS_W-1:0];
                CFG_CANCEL_LIMIT:  limit_reg <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            base_slot_reg <= '0;
            base_seq_reg  <= '0;
            nxt_reg       <= '0;
            nxt_slot_reg  <= '0;
            nxt_seq_reg   <= '0;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                base_reg      <= base_next;
                base_slot_reg <= base_slot_next;
                base_seq_reg  <= base_seq_next;
                nxt_reg       <= nxt_next;
                nxt_slot_reg  <= nxt_slot_next;
                nxt_seq_reg   <= nxt_seq_next;
                cnt_reg       <= cnt_next;
                done_reg      <= done_next;
                fail_reg      <= fail_next;
            end
        end
    end

    // Result payload and slot send times (no reset)
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg <= out_data_next;
            if (do_send)
                slot_mem[c_nxt_slot] <= in_ch.data.now_ms;
        end
    end

endmodule

// ===== hw/rtl/gbn_chk.sv =====
module gbn_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input gbn_pkg::out_item_t out_data
);
    import gbn_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // an empty output register never blocks input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output register");

    // a taken input beat shows up as a result beat in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("input beat taken without a result beat");

    // a step either sends or times out, never both; no send fields without a send
    a_send_tmo: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.send_valid && out_data.timeout_event)
                      && (out_data.send_valid
                          || (out_data.send_index == '0 && out_data.send_seq == '0)))
        else $error("inconsistent send/timeout result");

    // a transfer ends one way only
    a_end_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.failed && out_data.done_res))
        else $error("done and failed both set");

endmodule

bind go_back_n_sender_window_core gbn_chk u_gbn_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
